### src/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Needs signals named clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge, off during reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/mlfts_pkg.sv
// Shared types and constants of the multilevel feedback task scheduler.
// No dependencies; used by the channel interfaces and the top level.
package mlfts_pkg;

	localparam int LEVELS_DEF         = 4;
	localparam int QUEUE_DEPTH_DEF    = 16;
	localparam int RESOURCE_TYPES_DEF = 4;

	localparam int NUM_CFG   = 4;
	localparam int CFG_IDX_W = 2;
	localparam int LIMIT_W   = 2;
	localparam int ID_W      = 8;
	localparam int PRIO_W    = 3;
	localparam int TIME_W    = 16;
	localparam int LVL_OUT_W = 2;
	localparam int STATUS_W  = 3;

	localparam logic [TIME_W-1:0] QUANTUM = TIME_W'(1);

	localparam logic [LIMIT_W-1:0] LIMIT_RESET [NUM_CFG] = '{2'd2, 2'd1, 2'd1, 2'd2};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRINTER = 2'd0,
		CFG_SCANNER = 2'd1,
		CFG_MODEM   = 2'd2,
		CFG_DISC    = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		REQ_ARRIVAL = 1'b0,
		REQ_TICK    = 1'b1
	} req_type_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADMITTED     = 3'd0,
		ST_INVALID      = 3'd1,
		ST_TOO_MANY     = 3'd2,
		ST_QUEUE_FULL   = 3'd3,
		ST_SLICE_RUN    = 3'd4,
		ST_COMPLETED    = 3'd5,
		ST_IDLE         = 3'd6,
		ST_REQUEUE_DROP = 3'd7
	} status_t;

	// one queue slot: task id over remaining quanta
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] rem;
	} entry_t;

endpackage

### src/mlfts_req_if.sv
// Request channel of the scheduler: task arrivals and dispatch ticks.
// Depends on mlfts_pkg.
interface mlfts_req_if import mlfts_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                req_type;
	logic [ID_W-1:0]     task_id;
	logic [PRIO_W-1:0]   priority_level;
	logic [TIME_W-1:0]   run_time;
	logic [LIMIT_W-1:0]  need_printer;
	logic [LIMIT_W-1:0]  need_scanner;
	logic [LIMIT_W-1:0]  need_modem;
	logic [LIMIT_W-1:0]  need_disc;

	modport source (
		output valid, req_type, task_id, priority_level, run_time,
		output need_printer, need_scanner, need_modem, need_disc,
		input  ready
	);
	modport sink (
		input  valid, req_type, task_id, priority_level, run_time,
		input  need_printer, need_scanner, need_modem, need_disc,
		output ready
	);
endinterface

### src/mlfts_rsp_if.sv
// Result channel of the scheduler: one beat per request.
// Depends on mlfts_pkg.
interface mlfts_rsp_if import mlfts_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [ID_W-1:0]      out_task;
	logic [LVL_OUT_W-1:0] run_level;
	logic [TIME_W-1:0]    run_quanta;
	logic [TIME_W-1:0]    time_left;
	logic [LVL_OUT_W-1:0] next_level;

	modport source (
		output valid, status, out_task, run_level, run_quanta, time_left, next_level,
		input  ready
	);
	modport sink (
		input  valid, status, out_task, run_level, run_quanta, time_left, next_level,
		output ready
	);
endinterface

### src/mlfts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mlfts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/multilevel_feedback_task_scheduler.sv
// Top level of the multilevel feedback task scheduler.
// Depends on mlfts_pkg, mlfts_req_if, mlfts_rsp_if, mlfts_ram, assert_macros.svh.
//
// Usage:
//   req carries arrivals (req_type 0) and dispatch ticks (req_type 1); rsp returns
//   exactly one beat per request, in order. cfg_we/cfg_index/cfg_wdata write the
//   four resource limits; write them only while no request is in flight.
// Timing and throughput:
//   A request is resolved in the cycle it is accepted and its result sits in the
//   output register in the cycle after. One request per cycle is sustained while
//   rsp.ready stays high. The queue RAM is read ahead: every cycle the head slot of
//   the level that the next tick would serve is fetched, with a bypass when that
//   slot is written in the same cycle, so the RAM read port sets no extra wait.
// Stall:
//   req.ready is high while the output register is empty or being drained; if the
//   receiver holds rsp.ready low, one result waits and further requests stall.
// Reset:
//   arst_n clears all queues (head, tail, count per level) and the output valid,
//   and loads the default limits 2, 1, 1, 2. No clearing pass is needed.
`include "assert_macros.svh"

module multilevel_feedback_task_scheduler
	import mlfts_pkg::*;
#(
	parameter int LEVELS         = LEVELS_DEF,
	parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
	parameter int RESOURCE_TYPES = RESOURCE_TYPES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LIMIT_W-1:0]   cfg_wdata,
	mlfts_req_if.sink            req,
	mlfts_rsp_if.source          rsp
);

	localparam int LVL_W  = $clog2(LEVELS);
	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W = $clog2(LEVELS * QUEUE_DEPTH);
	localparam int ENT_W  = $bits(entry_t);

	localparam logic [LVL_W-1:0]  LAST_LVL  = LVL_W'(LEVELS - 1);
	localparam logic [PRIO_W:0]   LEVELS_CMP = (PRIO_W + 1)'(LEVELS);
	localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0]  LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

	function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
		wrap_next = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
	endfunction

	// queue bookkeeping
	logic [PTR_W-1:0]   head_q  [LEVELS];
	logic [PTR_W-1:0]   tail_q  [LEVELS];
	logic [CNT_W-1:0]   count_q [LEVELS];
	logic [PTR_W-1:0]   head_n  [LEVELS];
	logic [PTR_W-1:0]   tail_n  [LEVELS];
	logic [CNT_W-1:0]   count_n [LEVELS];
	logic [LIMIT_W-1:0] limit_q [NUM_CFG];
	logic [LIMIT_W-1:0] need    [NUM_CFG];

	// output register
	logic                 rsp_valid_q;
	status_t              status_q;
	logic [ID_W-1:0]      task_q;
	logic [LVL_OUT_W-1:0] run_level_q;
	logic [TIME_W-1:0]    run_quanta_q;
	logic [TIME_W-1:0]    time_left_q;
	logic [LVL_OUT_W-1:0] next_level_q;

	// decision
	logic                 accept;
	logic                 any_busy;
	logic [LVL_W-1:0]     pick_lvl;
	logic [LVL_W-1:0]     demote_lvl;
	logic [LVL_W-1:0]     arr_lvl;
	logic                 arr_invalid;
	logic                 res_over;
	entry_t               head_e;
	logic [TIME_W-1:0]    rem_next;
	status_t              o_status;
	logic [ID_W-1:0]      o_task;
	logic [LVL_OUT_W-1:0] o_run_level;
	logic [TIME_W-1:0]    o_quanta;
	logic [TIME_W-1:0]    o_left;
	logic [LVL_OUT_W-1:0] o_next_level;
	logic                 push_en;
	logic [LVL_W-1:0]     push_lvl;
	entry_t               push_e;
	logic                 pop_en;

	// RAM and lookahead read
	logic [ADDR_W-1:0]    wr_addr;
	logic [ADDR_W-1:0]    rd_addr;
	logic [ENT_W-1:0]     ram_rdata;
	logic [LVL_W-1:0]     look_lvl;
	logic                 bypass_q;
	entry_t               byp_data_q;

	assign accept    = req.valid && req.ready;
	assign req.ready = !rsp_valid_q || rsp.ready;

	assign need[0] = req.need_printer;
	assign need[1] = req.need_scanner;
	assign need[2] = req.need_modem;
	assign need[3] = req.need_disc;

	assign arr_lvl     = req.priority_level[LVL_W-1:0];
	assign arr_invalid = ({1'b0, req.priority_level} >= LEVELS_CMP) || (req.run_time == '0);

	always_comb begin
		res_over = 1'b0;
		for (int i = 0; i < NUM_CFG; i++) begin
			if (i < RESOURCE_TYPES && need[i] > limit_q[i]) begin
				res_over = 1'b1;
			end
		end
	end

	// first non-empty level, level 0 wins
	always_comb begin
		any_busy = 1'b0;
		pick_lvl = '0;
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (count_q[l] != '0) begin
				any_busy = 1'b1;
				pick_lvl = LVL_W'(l);
			end
		end
	end

	assign head_e     = bypass_q ? byp_data_q : entry_t'(ram_rdata);
	assign demote_lvl = (pick_lvl == LAST_LVL) ? pick_lvl : pick_lvl + LVL_W'(1);
	assign rem_next   = (head_e.rem > QUANTUM) ? head_e.rem - QUANTUM : '0;

	always_comb begin
		o_status     = ST_IDLE;
		o_task       = '0;
		o_run_level  = '0;
		o_quanta     = '0;
		o_left       = '0;
		o_next_level = '0;
		push_en      = 1'b0;
		push_lvl     = '0;
		push_e       = '{id: req.task_id, rem: req.run_time};
		pop_en       = 1'b0;
		if (accept) begin
			if (req.req_type == REQ_ARRIVAL) begin
				o_task = req.task_id;
				if (arr_invalid) begin
					o_status = ST_INVALID;
				end else if (res_over) begin
					o_status = ST_TOO_MANY;
				end else if (count_q[arr_lvl] == FULL_CNT) begin
					o_status = ST_QUEUE_FULL;
				end else begin
					o_status = ST_ADMITTED;
					push_en  = 1'b1;
					push_lvl = arr_lvl;
				end
			end else if (any_busy) begin
				pop_en      = 1'b1;
				o_task      = head_e.id;
				o_run_level = LVL_OUT_W'(pick_lvl);
				if (pick_lvl == '0) begin
					o_status = ST_COMPLETED;
					o_quanta = head_e.rem;
				end else begin
					o_quanta = QUANTUM;
					o_left   = rem_next;
					if (rem_next == '0) begin
						o_status = ST_COMPLETED;
					end else begin
						o_next_level = LVL_OUT_W'(demote_lvl);
						push_e       = '{id: head_e.id, rem: rem_next};
						// the last level pops before it pushes, so it always has room
						if (demote_lvl == pick_lvl || count_q[demote_lvl] != FULL_CNT) begin
							o_status = ST_SLICE_RUN;
							push_en  = 1'b1;
							push_lvl = demote_lvl;
						end else begin
							o_status = ST_REQUEUE_DROP;
						end
					end
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LEVELS; l++) begin
			head_n[l]  = head_q[l];
			tail_n[l]  = tail_q[l];
			count_n[l] = count_q[l];
			if (pop_en && pick_lvl == LVL_W'(l)) begin
				head_n[l]  = wrap_next(head_q[l]);
				count_n[l] = count_n[l] - CNT_W'(1);
			end
			if (push_en && push_lvl == LVL_W'(l)) begin
				tail_n[l]  = wrap_next(tail_q[l]);
				count_n[l] = count_n[l] + CNT_W'(1);
			end
		end
	end

	// level the next tick would serve, from the updated counts
	always_comb begin
		look_lvl = '0;
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (count_n[l] != '0) begin
				look_lvl = LVL_W'(l);
			end
		end
	end

	assign wr_addr = ADDR_W'(push_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_q[push_lvl]);
	assign rd_addr = ADDR_W'(look_lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_n[look_lvl]);

	mlfts_ram #(
		.WIDTH (ENT_W),
		.DEPTH (LEVELS * QUEUE_DEPTH)
	) u_queue_ram (
		.clk   (clk),
		.we    (push_en),
		.waddr (wr_addr),
		.wdata (push_e),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l]  <= '0;
				tail_q[l]  <= '0;
				count_q[l] <= '0;
			end
			bypass_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l]  <= head_n[l];
				tail_q[l]  <= tail_n[l];
				count_q[l] <= count_n[l];
			end
			// slot being written is the one fetched: RAM returns stale data
			bypass_q <= push_en && (wr_addr == rd_addr);
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) begin
				limit_q[i] <= LIMIT_RESET[i];
			end
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PRINTER: limit_q[CFG_PRINTER] <= cfg_wdata;
				CFG_SCANNER: limit_q[CFG_SCANNER] <= cfg_wdata;
				CFG_MODEM:   limit_q[CFG_MODEM]   <= cfg_wdata;
				CFG_DISC:    limit_q[CFG_DISC]    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= push_e;
		if (accept) begin
			status_q     <= o_status;
			task_q       <= o_task;
			run_level_q  <= o_run_level;
			run_quanta_q <= o_quanta;
			time_left_q  <= o_left;
			next_level_q <= o_next_level;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.out_task   = task_q;
	assign rsp.run_level  = run_level_q;
	assign rsp.run_quanta = run_quanta_q;
	assign rsp.time_left  = time_left_q;
	assign rsp.next_level = next_level_q;

	// ---- assertions ----
	for (genvar g = 0; g < LEVELS; g++) begin : g_chk
		logic [PTR_W:0] ptr_sum;
		logic [PTR_W:0] ptr_wrap;
		assign ptr_sum  = {1'b0, head_q[g]} + (PTR_W + 1)'(count_q[g]);
		assign ptr_wrap = (ptr_sum >= (PTR_W + 1)'(QUEUE_DEPTH)) ?
			ptr_sum - (PTR_W + 1)'(QUEUE_DEPTH) : ptr_sum;

		`ASSERT_CLK(a_count_range, count_q[g] <= FULL_CNT, "queue count above depth")
		`ASSERT_CLK(a_ptr_track, tail_q[g] == ptr_wrap[PTR_W-1:0], "tail out of step with head and count")
	end

	`ASSERT_CLK(a_requeue_level, rsp.valid && (rsp.status == ST_SLICE_RUN || rsp.status == ST_REQUEUE_DROP) |-> rsp.run_level != '0, "requeue from level 0")
	`ASSERT_NEXT(a_arrival_code, accept && req.req_type == REQ_ARRIVAL, rsp.valid && rsp.status <= ST_QUEUE_FULL, "arrival gave a dispatch status")

endmodule
